// ===== src/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// Task timing statistics: shared package
// Field widths, channel codes and the per-channel statistics record.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

   // Field widths
   localparam int SLOT_FIELD_W = 4;
   localparam int TIME_W       = 32;
   localparam int STAT_W       = 16;
   localparam int TOTAL_W      = 64;
   localparam int COUNT_W      = 32;
   localparam int SHIFT_W      = 4;
   localparam int CHANNEL_W    = 2;

   // Structure
   localparam int NUM_CHANNELS       = 3;
   localparam int SLOT_CODES         = 2 ** SLOT_FIELD_W;
   localparam int DEFAULT_TASK_SLOTS = 16;

   // Constants
   localparam logic [TIME_W-1:0]  CLAMP_LIMIT = 32'd65535;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd3;

   // Channel codes, in the order results are sent
   typedef enum logic [CHANNEL_W-1:0] {
      CH_PROCESS   = 2'd0,
      CH_KERNEL    = 2'd1,
      CH_EXCEPTION = 2'd2
   } channel_type;

   // One channel of one slot
   typedef struct packed {
      logic [STAT_W-1:0]  minimum;
      logic [STAT_W-1:0]  maximum;
      logic [STAT_W-1:0]  average;
      logic [TOTAL_W-1:0] total;
   } stat_entry_type;

   localparam int STAT_ENTRY_W = $bits(stat_entry_type);

endpackage

`default_nettype wire

// ===== src/tts_ram.sv =====
// ----------------------------------------------------------------------------
// Task timing statistics: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/tts_stat_update.sv =====
// ----------------------------------------------------------------------------
// Task timing statistics: channel update
// Folds one duration into the minimum, maximum, running average and total.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_stat_update (
   input  tts_pkg::stat_entry_type            old_entry,
   input  logic [tts_pkg::TIME_W-1:0]          duration,
   input  logic [tts_pkg::SHIFT_W-1:0]         shift,
   output tts_pkg::stat_entry_type            new_entry
);
   import tts_pkg::*;

   logic [STAT_W-1:0] clamped;
   logic [STAT_W-1:0] avg_seed;
   logic [TIME_W-1:0] acc;

   // Durations above the 16-bit range count as zero for min/max and the average seed
   assign clamped = (duration > CLAMP_LIMIT) ? '0 : duration[STAT_W-1:0];

   // Zero average is seeded with the clamped value before the blend
   assign avg_seed = (old_entry.average == '0) ? clamped : old_entry.average;

   // avg*(2^shift-1) + v as a shift and subtract, wrapping at 32 bits
   assign acc = (TIME_W'(avg_seed) << shift) - TIME_W'(avg_seed) + duration;

   always_comb begin
      new_entry = old_entry;
      // minimum of zero means unset
      if ((old_entry.minimum == '0) || (old_entry.minimum > clamped)) begin
         new_entry.minimum = clamped;
      end
      if (old_entry.maximum < clamped) begin
         new_entry.maximum = clamped;
      end
      new_entry.average = STAT_W'(acc >> shift);
      new_entry.total   = old_entry.total + TOTAL_W'(duration);
   end

endmodule

`default_nettype wire

// ===== src/task_timing_statistics_top.sv =====
// ----------------------------------------------------------------------------
// Task timing statistics: top level
// Per-slot execution counts and process/kernel/exception timing statistics.
// ----------------------------------------------------------------------------
// A context switch is taken when start is high and busy is low. Its three
// results (process, kernel, exception channel) follow on rsp_valid in
// consecutive cycles; rsp_last marks the exception result. The receiver
// cannot stall, so results must be taken as they come. A new switch can
// be taken while the exception channel of the previous one is written: the
// statistics memory has one read and one write port and each channel is
// one read-modify-write pass through it. busy is high while the first two
// channels are in progress. Reset clears all statistics at once through
// per-entry valid bits; no clearing pass is needed. csr_wr_en writes the
// averaging shift and should only be used while no switch is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module task_timing_statistics_top #(
   parameter int TASK_SLOTS = tts_pkg::DEFAULT_TASK_SLOTS
) (
   input  logic                                clock,
   input  logic                                reset,
   // Command channel
   input  logic                                start,
   output logic                                busy,
   input  logic [tts_pkg::SLOT_FIELD_W-1:0]    req_switched_out_slot,
   input  logic [tts_pkg::SLOT_FIELD_W-1:0]    req_running_slot,
   input  logic [tts_pkg::TIME_W-1:0]          req_time_start,
   input  logic [tts_pkg::TIME_W-1:0]          req_time_stop,
   input  logic [tts_pkg::TIME_W-1:0]          req_time_last_start,
   input  logic [tts_pkg::TIME_W-1:0]          req_exception_time,
   // Result channel
   output logic                                rsp_valid,
   output logic [tts_pkg::CHANNEL_W-1:0]       rsp_channel,
   output logic [tts_pkg::STAT_W-1:0]          rsp_minimum,
   output logic [tts_pkg::STAT_W-1:0]          rsp_maximum,
   output logic [tts_pkg::STAT_W-1:0]          rsp_average,
   output logic [tts_pkg::TOTAL_W-1:0]         rsp_total,
   output logic [tts_pkg::COUNT_W-1:0]         rsp_execution_count,
   output logic                                rsp_last,
   // Configuration
   input  logic                                csr_wr_en,
   input  logic [tts_pkg::SHIFT_W-1:0]         csr_wr_data
);
   import tts_pkg::*;

   localparam int SLOT_W    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int ENTRIES   = NUM_CHANNELS * TASK_SLOTS;
   localparam int ENTRY_W   = $clog2(ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CH0  = 4'b0010,
      ST_CH1  = 4'b0100,
      ST_CH2  = 4'b1000
   } state_type;

   // Entry of one channel of one slot: 3*slot + channel
   function automatic logic [ENTRY_W-1:0] entry_of(input logic [SLOT_W-1:0] slot,
                                                   input channel_type ch);
      entry_of = ENTRY_W'(slot) + ENTRY_W'(slot) + ENTRY_W'(slot) + ENTRY_W'(ch);
   endfunction

   // Slot codes reduced modulo the table size
   logic [SLOT_W-1:0] slot_lut [SLOT_CODES];
   for (genvar g = 0; g < SLOT_CODES; g++) begin : g_slot_lut
      localparam int SLOT_RESIDUE = g % TASK_SLOTS;
      assign slot_lut[g] = SLOT_W'(SLOT_RESIDUE);
   end

   state_type          state_ff, state_in;
   logic [SHIFT_W-1:0] shift_ff;
   logic               accept;

   // Input register
   logic [SLOT_W-1:0]  out_slot_ff;
   logic [SLOT_W-1:0]  run_slot_ff;
   logic [TIME_W-1:0]  dur_ff [NUM_CHANNELS];
   logic [TIME_W-1:0]  span;
   logic [TIME_W-1:0]  dur_process_in;
   logic [TIME_W-1:0]  dur_kernel_in;

   // Memory side
   logic [ENTRIES-1:0]    stat_valid_ff;
   logic [TASK_SLOTS-1:0] count_valid_ff;
   logic                  stat_rd_valid_ff;
   logic                  count_rd_valid_ff;
   logic [ENTRY_W-1:0]    stat_rd_addr;
   logic [ENTRY_W-1:0]    stat_wr_addr;
   logic [STAT_ENTRY_W-1:0] stat_rd_data;
   logic [SLOT_W-1:0]     count_rd_addr;
   logic [COUNT_W-1:0]    count_rd_data;
   logic [COUNT_W-1:0]    count_new;
   logic                  stat_wr_en;
   logic                  count_wr_en;

   // Per-channel work
   channel_type        cur_channel;
   logic [TIME_W-1:0]  cur_dur;
   stat_entry_type     old_entry;
   stat_entry_type     new_entry;

   // Result register
   logic               rsp_valid_ff;
   channel_type        rsp_channel_ff;
   stat_entry_type     rsp_entry_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_last_ff;

   // Sequencer: one channel per cycle, next switch may enter on the last one
   always_comb begin
      unique case (state_ff)
         ST_CH0: begin
            cur_channel  = CH_PROCESS;
            cur_dur      = dur_ff[0];
            stat_rd_addr = entry_of(out_slot_ff, CH_KERNEL);
            busy         = 1'b1;
            state_in     = ST_CH1;
         end
         ST_CH1: begin
            cur_channel  = CH_KERNEL;
            cur_dur      = dur_ff[1];
            stat_rd_addr = entry_of(out_slot_ff, CH_EXCEPTION);
            busy         = 1'b1;
            state_in     = ST_CH2;
         end
         ST_CH2: begin
            cur_channel  = CH_EXCEPTION;
            cur_dur      = dur_ff[2];
            stat_rd_addr = entry_of(slot_lut[req_switched_out_slot], CH_PROCESS);
            busy         = 1'b0;
            state_in     = start ? ST_CH0 : ST_IDLE;
         end
         default: begin
            cur_channel  = CH_PROCESS;
            cur_dur      = dur_ff[0];
            stat_rd_addr = entry_of(slot_lut[req_switched_out_slot], CH_PROCESS);
            busy         = 1'b0;
            state_in     = start ? ST_CH0 : ST_IDLE;
         end
      endcase
   end

   assign accept = start && !busy;

   // Durations modulo 2^32; the process duration floors at zero
   assign span           = req_time_stop - req_time_last_start;
   assign dur_process_in = (span < req_exception_time) ? '0 : (span - req_exception_time);
   assign dur_kernel_in  = req_time_start - req_time_stop;

   // Statistics memory: entry read in the state before its update, written back after it
   assign stat_wr_en   = (state_ff != ST_IDLE);
   assign stat_wr_addr = entry_of(out_slot_ff, cur_channel);

   tts_ram #(
      .WIDTH (STAT_ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_stat_ram (
      .clock   (clock),
      .wr_en   (stat_wr_en),
      .wr_addr (stat_wr_addr),
      .wr_data (new_entry),
      .rd_addr (stat_rd_addr),
      .rd_data (stat_rd_data)
   );

   // Never-written entries read as zero
   assign old_entry = stat_rd_valid_ff ? stat_entry_type'(stat_rd_data) : '0;

   tts_stat_update u_stat_update (
      .old_entry (old_entry),
      .duration  (cur_dur),
      .shift     (shift_ff),
      .new_entry (new_entry)
   );

   // Execution count memory: read at the transfer, bumped in ST_CH0
   assign count_rd_addr = slot_lut[req_running_slot];
   assign count_wr_en   = (state_ff == ST_CH0);
   assign count_new     = (count_rd_valid_ff ? count_rd_data : '0) + COUNT_W'(1);

   tts_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (TASK_SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (count_wr_en),
      .wr_addr (run_slot_ff),
      .wr_data (count_new),
      .rd_addr (count_rd_addr),
      .rd_data (count_rd_data)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         shift_ff          <= SHIFT_RESET;
         stat_valid_ff     <= '0;
         count_valid_ff    <= '0;
         stat_rd_valid_ff  <= 1'b0;
         count_rd_valid_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         stat_rd_valid_ff  <= stat_valid_ff[stat_rd_addr];
         count_rd_valid_ff <= count_valid_ff[count_rd_addr];
         rsp_valid_ff      <= stat_wr_en;
         if (csr_wr_en) begin
            shift_ff <= csr_wr_data;
         end
         if (stat_wr_en) begin
            stat_valid_ff[stat_wr_addr] <= 1'b1;
         end
         if (count_wr_en) begin
            count_valid_ff[run_slot_ff] <= 1'b1;
         end
      end
   end

   // Input register, loaded on each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         out_slot_ff <= slot_lut[req_switched_out_slot];
         run_slot_ff <= slot_lut[req_running_slot];
         dur_ff[0]   <= dur_process_in;
         dur_ff[1]   <= dur_kernel_in;
         dur_ff[2]   <= req_exception_time;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (stat_wr_en) begin
         rsp_channel_ff <= cur_channel;
         rsp_entry_ff   <= new_entry;
         rsp_last_ff    <= (cur_channel == CH_EXCEPTION);
      end
      if (count_wr_en) begin
         rsp_count_ff <= count_new;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_channel         = CHANNEL_W'(rsp_channel_ff);
   assign rsp_minimum         = rsp_entry_ff.minimum;
   assign rsp_maximum         = rsp_entry_ff.maximum;
   assign rsp_average         = rsp_entry_ff.average;
   assign rsp_total           = rsp_entry_ff.total;
   assign rsp_execution_count = rsp_count_ff;
   assign rsp_last            = rsp_last_ff;

   // Each transfer yields process, kernel, exception results in order
   a_result_order: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 (rsp_valid && rsp_channel == CH_PROCESS && !rsp_last)
                 ##1 (rsp_valid && rsp_channel == CH_KERNEL && !rsp_last)
                 ##1 (rsp_valid && rsp_channel == CH_EXCEPTION && rsp_last))
      else $error("result sequence broken after transfer");

   // Execution count is the same across the results of one switch
   a_count_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_channel != CH_PROCESS) |-> $stable(rsp_execution_count))
      else $error("execution count changed within one switch");

   // Maximum never falls below minimum
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_maximum >= rsp_minimum))
      else $error("maximum below minimum");

   // No new transfer while the first two channels are in progress
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CH0 || state_ff == ST_CH1) |-> !accept)
      else $error("transfer taken mid-switch");

endmodule

`default_nettype wire
